FILE: src/ren_pkg.sv
// Shared types and constants for the ring energy normaliser.
package ren_pkg;

  localparam int SUM_W = 40;  // wrapping sum width
  localparam int REM_W = 48;  // sequential remainder width
  localparam int NUM_W = 56;  // |ring| * 2^24
  localparam int DEN_W = 47;  // positive divisor magnitude

  localparam logic [2:0] MODE_SET     = 3'd1;
  localparam logic [2:0] MODE_SEQ     = 3'd2;
  localparam logic [2:0] MODE_EVENT   = 3'd3;
  localparam logic [2:0] MODE_SECTION = 3'd4;

  localparam logic [1:0] REG_STOP     = 2'd0;
  localparam logic [1:0] REG_THR      = 2'd1;
  localparam logic [1:0] REG_MODES    = 2'd2;
  localparam logic [1:0] REG_SECTIONS = 2'd3;

  typedef struct packed {
    logic signed [31:0] ring_energy;
    logic [2:0]         set_index;
    logic               last_in_event;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] norm_value;
    logic [2:0]         out_set;
    logic               saturated;
    logic               overflow;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic [30:0] stop_level;
    logic [30:0] min_divisor;
    logic [23:0] set_modes;
    logic [7:0]  set_sections;
  } cfg_t;

  typedef struct packed {
    logic accept;  // store one ring, update sums
    logic start;   // begin the normalise pass
    logic rd;      // read the current ring
    logic sel;     // pick the divisor
    logic issue;   // start divider or bypass
    logic push;    // load the output register
    logic next;    // advance ring pointer
    logic clear;   // drop event state
  } cmd_t;

  typedef struct packed {
    logic use_div;
    logic div_done;
    logic out_free;
    logic last_ring;
  } sts_t;

endpackage

FILE: src/ren_div.sv
// Radix-2 restoring divider: 32 quotient bits, early overflow on a large quotient.
module ren_div import ren_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic             ovf,
  output logic [31:0]      quo
);

  logic             busy_r;
  logic             done_r;
  logic             ovf_r;
  logic [4:0]       cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [31:0]      quo_r;
  logic [REM_W-1:0] sh;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;
  logic [31:0]      quo_nxt;

  always_comb begin
    sh      = {rem_r[REM_W-2:0], quo_r[31]};
    ge      = sh >= {1'b0, den};
    rem_nxt = ge ? sh - {1'b0, den} : sh;
    quo_nxt = {quo_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // quotient needs more than 32 bits: flag it, no iterations
        if (REM_W'(num[NUM_W-1:32]) >= {1'b0, den}) begin
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num[NUM_W-1:32]);
      quo_r <= num[31:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule

FILE: src/ren_ctrl.sv
// Controller: sequences loading, per-ring normalisation and result hand-off.
module ren_ctrl import ren_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  sts_t     sts,
  output cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_SEL, S_ISSUE, S_WAIT, S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = sts.use_div ? S_WAIT : S_PUSH;
      end
      S_WAIT: begin
        if (sts.div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.last_ring) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: src/ren_dp.sv
// Datapath: ring store, sums, divisor selection, divider and output register.
module ren_dp import ren_pkg::*; #(
  parameter int MAX_RINGS = 64,
  parameter int MAX_SETS  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(MAX_RINGS);
  localparam int CW = $clog2(MAX_RINGS + 1);
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam logic [2:0] LAST_SET = 3'(MAX_SETS - 1);

  logic [34:0] mem [MAX_RINGS];
  logic [34:0] rd_q_r;

  logic signed [SUM_W-1:0] set_sum_r [MAX_SETS];
  logic signed [SUM_W-1:0] em_r, had_r;
  logic [CW-1:0]           count_r, idx_r;
  logic                    ovf_r;

  logic                    seen_r  [MAX_SETS];
  logic                    fixed_r [MAX_SETS];
  logic signed [REM_W-1:0] rem_r   [MAX_SETS];
  logic signed [31:0]      prev_r  [MAX_SETS];
  logic signed [REM_W-1:0] event_r, stop_r;

  logic signed [REM_W-1:0] d_r;
  logic                    use_r, div_r;
  logic signed [31:0]      v_r;
  logic [2:0]              t_r;

  logic                    ov_valid_r;
  out_item_t               ov_data_r;

  // load side
  logic [2:0]              s_cl;
  logic [SW-1:0]           s_i;
  logic signed [SUM_W-1:0] e40;

  always_comb begin
    s_cl = ({1'b0, in_data.set_index} >= 4'(MAX_SETS)) ? LAST_SET : in_data.set_index;
    s_i  = s_cl[SW-1:0];
    e40  = SUM_W'(in_data.ring_energy);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (count_r < CW'(MAX_RINGS)))
      mem[count_r[AW-1:0]] <= {s_cl, in_data.ring_energy};
    if (cmd.rd)
      rd_q_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int k = 0; k < MAX_SETS; k++) set_sum_r[k] <= '0;
      em_r    <= '0;
      had_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (count_r < CW'(MAX_RINGS)) begin
        count_r        <= count_r + CW'(1);
        set_sum_r[s_i] <= set_sum_r[s_i] + e40;
        if (cfg.set_sections[s_cl]) had_r <= had_r + e40;
        else                        em_r  <= em_r + e40;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // divisor selection for the ring just read
  logic signed [31:0]      v;
  logic [2:0]              t;
  logic [SW-1:0]           ti;
  logic [2:0]              mode;
  logic signed [REM_W-1:0] sum48, remn, d_nxt;
  logic                    use_nxt;

  always_comb begin
    v       = $signed(rd_q_r[31:0]);
    t       = rd_q_r[34:32];
    ti      = t[SW-1:0];
    mode    = 3'(cfg.set_modes >> (5'(t) * 5'd3));
    sum48   = REM_W'(set_sum_r[ti]);
    remn    = rem_r[ti] - REM_W'(prev_r[ti]);
    d_nxt   = '0;
    use_nxt = 1'b1;
    case (mode)
      MODE_SET:     d_nxt = sum48;
      MODE_EVENT:   d_nxt = event_r;
      MODE_SECTION: d_nxt = cfg.set_sections[t] ? REM_W'(had_r) : REM_W'(em_r);
      MODE_SEQ: begin
        if (sum48 < stop_r || !seen_r[ti]) d_nxt = sum48;
        else if (fixed_r[ti] || remn < stop_r) d_nxt = sum48;
        else d_nxt = remn;
      end
      default: use_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      for (int k = 0; k < MAX_SETS; k++) begin
        seen_r[k]  <= 1'b0;
        fixed_r[k] <= 1'b0;
      end
    end else if (cmd.sel && mode == MODE_SEQ) begin
      seen_r[ti] <= 1'b1;
      if (sum48 >= stop_r && seen_r[ti] && (fixed_r[ti] || remn < stop_r))
        fixed_r[ti] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      event_r <= REM_W'(SUM_W'(em_r + had_r));
      stop_r  <= (cfg.stop_level < cfg.min_divisor) ?
                 REM_W'(cfg.min_divisor) : REM_W'(cfg.stop_level);
      idx_r   <= '0;
    end else if (cmd.next) begin
      idx_r   <= idx_r + CW'(1);
    end
    if (cmd.sel) begin
      if (mode == MODE_SEQ && sum48 >= stop_r) begin
        rem_r[ti]  <= seen_r[ti] ? remn : sum48;
      end
      if (mode == MODE_SEQ) prev_r[ti] <= v;
      d_r   <= d_nxt;
      use_r <= use_nxt;
      v_r   <= v;
      t_r   <= t;
    end
    if (cmd.issue) div_r <= sts.use_div;
  end

  // divider
  logic [31:0]      mag;
  logic             div_done, div_ovf;
  logic [31:0]      div_q;

  assign mag = v_r[31] ? 32'(-33'(v_r)) : 32'(v_r);

  ren_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.issue && sts.use_div),
    .num   ({mag, 24'd0}),
    .den   (d_r[DEN_W-1:0]),
    .done  (div_done),
    .ovf   (div_ovf),
    .quo   (div_q)
  );

  // result formatting
  logic signed [43:0] byp;
  logic signed [31:0] res;
  logic               sat;

  always_comb begin
    byp = 44'(v_r) <<< 12;
    res = '0;
    sat = 1'b0;
    if (div_r) begin
      if (v_r[31]) begin
        if (div_ovf || div_q > 32'h8000_0000) begin
          sat = 1'b1;
          res = 32'sh8000_0000;
        end else begin
          res = $signed(~div_q + 32'd1);
        end
      end else if (div_ovf || div_q[31]) begin
        sat = 1'b1;
        res = 32'sh7FFF_FFFF;
      end else begin
        res = $signed(div_q);
      end
    end else if (byp[43:31] != {13{byp[43]}}) begin
      sat = 1'b1;
      res = byp[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res = byp[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_valid_r <= 1'b0;
    end else if (cmd.push) begin
      ov_valid_r <= 1'b1;
    end else if (out_ready) begin
      ov_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ov_data_r.norm_value <= res;
      ov_data_r.out_set    <= t_r;
      ov_data_r.saturated  <= sat;
      ov_data_r.overflow   <= ovf_r;
      ov_data_r.last_out   <= sts.last_ring;
    end
  end

  always_comb begin
    // signed compare: a negative divisor never divides
    sts.use_div   = use_r && (d_r > $signed(REM_W'(cfg.min_divisor)));
    sts.div_done  = div_done;
    sts.out_free  = !ov_valid_r || out_ready;
    sts.last_ring = (idx_r + CW'(1)) == count_r;
  end

  assign out_valid = ov_valid_r;
  assign out_data  = ov_data_r;

endmodule

FILE: src/ring_energy_normaliser.sv
// Ring energy normaliser: rings are loaded one per cycle, then normalised one by one.
// Load: one ring per cycle while idle; the last ring of an event starts the pass.
// Pass: each ring is read, its divisor selected, then issued to the 32-step serial
//   divider or bypassed, and pushed; a push waits for a free output register.
// in_ready is low during the pass; the last result may still wait while loading restarts.
// Reset (synchronous, rst_n low) clears sums, counts and flags, and loads register defaults.
module ring_energy_normaliser import ren_pkg::*; #(
  parameter int MAX_RINGS = 64,
  parameter int MAX_SETS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_level   <= 31'd409600;
      cfg_r.min_divisor  <= 31'd4;
      cfg_r.set_modes    <= '0;
      cfg_r.set_sections <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_STOP:     cfg_r.stop_level   <= pwdata[30:0];
        REG_THR:      cfg_r.min_divisor  <= pwdata[30:0];
        REG_MODES:    cfg_r.set_modes    <= pwdata[23:0];
        REG_SECTIONS: cfg_r.set_sections <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STOP:     prdata = {1'b0, cfg_r.stop_level};
      REG_THR:      prdata = {1'b0, cfg_r.min_divisor};
      REG_MODES:    prdata = {8'd0, cfg_r.set_modes};
      REG_SECTIONS: prdata = {24'd0, cfg_r.set_sections};
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  ren_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_in_event),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ren_dp #(
    .MAX_RINGS (MAX_RINGS),
    .MAX_SETS  (MAX_SETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/ren_chk.sv
// Port-level checker for the ring energy normaliser, bound to the top level.
module ren_chk import ren_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // a result waiting for the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // the last ring of an event closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_in_event |=> !in_ready)
    else $error("input still open after last ring");

  // a clipped value is one of the two range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.norm_value == 32'sh7FFF_FFFF || out_data.norm_value == 32'sh8000_0000)
    else $error("saturated flag without a limit value");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind ring_energy_normaliser ren_chk u_chk (.*);
